FILE: rtl/keyboard_scan_code_encoder_defines.svh
// Assertion macros for the keyboard scan code encoder.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef KEYBOARD_SCAN_CODE_ENCODER_DEFINES_SVH
`define KEYBOARD_SCAN_CODE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KSCE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define KSCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/kbd_enc_pkg.sv
// Package for the keyboard scan code encoder: types, codes and the scan ROM.
// No dependencies.
`default_nettype none

package kbd_enc_pkg;

	localparam logic       CmdPress   = 1'b0;
	localparam logic       CmdRelease = 1'b1;
	localparam logic [7:0] KeyCaps    = 8'h14;
	localparam logic [7:0] KeyKana    = 8'h15;
	localparam logic [6:0] ScanCaps   = 7'h71;
	localparam logic [6:0] ScanKana   = 7'h72;
	localparam logic [7:0] NoMap      = 8'hff;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// One host key event.
	typedef struct packed {
		logic       repeat_req;
		logic [7:0] key_code;
		logic       command;
	} evt_t;

	// Bytes produced by one event; first_byte goes out first.
	typedef struct packed {
		logic [1:0] n_bytes;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
	} res_t;

	// Output queue entry.
	typedef struct packed {
		logic       last;
		logic [7:0] scan_byte;
	} q_entry_t;

	// Host code to scan code; NoMap marks an unmapped code.
	function automatic logic [7:0] scan_rom(input logic [7:0] code);
		logic [7:0] v;
		case (code)
			8'h08: v = 8'h0e; 8'h09: v = 8'h0f; 8'h0d: v = 8'h1c;
			8'h10: v = 8'h70; 8'h11: v = 8'h74; 8'h12: v = 8'h73; 8'h13: v = 8'h60;
			8'h1b: v = 8'h00; 8'h1c: v = 8'h35; 8'h1d: v = 8'h51;
			8'h20: v = 8'h34; 8'h21: v = 8'h36; 8'h22: v = 8'h37; 8'h23: v = 8'h3f;
			8'h24: v = 8'h3e; 8'h25: v = 8'h3b; 8'h26: v = 8'h3a; 8'h27: v = 8'h3c;
			8'h28: v = 8'h3d; 8'h2d: v = 8'h38; 8'h2e: v = 8'h39;
			8'h30: v = 8'h0a; 8'h31: v = 8'h01; 8'h32: v = 8'h02; 8'h33: v = 8'h03;
			8'h34: v = 8'h04; 8'h35: v = 8'h05; 8'h36: v = 8'h06; 8'h37: v = 8'h07;
			8'h38: v = 8'h08; 8'h39: v = 8'h09;
			8'h40: v = 8'h0a; 8'h41: v = 8'h1d; 8'h42: v = 8'h2d; 8'h43: v = 8'h2b;
			8'h44: v = 8'h1f; 8'h45: v = 8'h12; 8'h46: v = 8'h20; 8'h47: v = 8'h21;
			8'h48: v = 8'h22; 8'h49: v = 8'h17; 8'h4a: v = 8'h23; 8'h4b: v = 8'h24;
			8'h4c: v = 8'h25; 8'h4d: v = 8'h2f; 8'h4e: v = 8'h2e; 8'h4f: v = 8'h18;
			8'h50: v = 8'h19; 8'h51: v = 8'h10; 8'h52: v = 8'h13; 8'h53: v = 8'h1e;
			8'h54: v = 8'h14; 8'h55: v = 8'h16; 8'h56: v = 8'h2c; 8'h57: v = 8'h11;
			8'h58: v = 8'h2a; 8'h59: v = 8'h15; 8'h5a: v = 8'h29;
			8'h60: v = 8'h4e; 8'h61: v = 8'h4a; 8'h62: v = 8'h4b; 8'h63: v = 8'h4c;
			8'h64: v = 8'h46; 8'h65: v = 8'h47; 8'h66: v = 8'h48; 8'h67: v = 8'h42;
			8'h68: v = 8'h43; 8'h69: v = 8'h44; 8'h6a: v = 8'h45; 8'h6b: v = 8'h49;
			8'h6d: v = 8'h40; 8'h6e: v = 8'h50; 8'h6f: v = 8'h41;
			8'h70: v = 8'h62; 8'h71: v = 8'h63; 8'h72: v = 8'h64; 8'h73: v = 8'h65;
			8'h74: v = 8'h66; 8'h75: v = 8'h67; 8'h76: v = 8'h68; 8'h77: v = 8'h69;
			8'h78: v = 8'h6a; 8'h79: v = 8'h6b; 8'h7a: v = 8'h60; 8'h7b: v = 8'h61;
			8'hba: v = 8'h27; 8'hbb: v = 8'h26; 8'hbc: v = 8'h30; 8'hbd: v = 8'h0b;
			8'hbe: v = 8'h31; 8'hbf: v = 8'h32;
			8'hc0: v = 8'h1a;
			8'hdb: v = 8'h1b; 8'hdc: v = 8'h0d; 8'hdd: v = 8'h28; 8'hde: v = 8'h0c;
			8'he2: v = 8'h33;
			default: v = NoMap;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/keyboard_scan_code_encoder.sv
// Keyboard scan code encoder, top level. An event is held in the input register, then
// resolved into the output queue, which offers its first byte on m_tdata. One event per
// cycle while each makes one byte at most and m_tready is high; two-byte events go out
// one byte per transfer. A full output queue stalls the input register; s_tready drops.
// Reset (arst_n low, asynchronous) clears both locks, the held-key map and the queue.
// Depends on kbd_enc_pkg, kbd_enc_keystate, kbd_enc_outq and the assertion macro header.
`default_nettype none
`include "keyboard_scan_code_encoder_defines.svh"

module keyboard_scan_code_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Event input
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] key_code
	input  wire logic [1:0] s_tuser,   // [0] command, [1] repeat_req
	// Scan byte output
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] scan_byte
	output logic            m_tlast    // final byte of the event
);
	import kbd_enc_pkg::*;

	// Input register stage
	evt_t evt_s1;
	logic valid_s1;

	res_t res;
	logic room;
	logic fire;
	logic s_xfer;

	// The event in the input register is resolved once the queue can take two bytes;
	// the held map and locks update at that same edge, so the next event sees them.
	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;
	assign s_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_xfer || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			evt_s1 <= '{repeat_req: s_tuser[1], key_code: s_tdata, command: s_tuser[0]};
		end
	end

	kbd_enc_keystate u_keystate (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_s1),
		.fire   (fire),
		.res    (res)
	);

	kbd_enc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.push     (fire),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// A stalled event must hold in the input register.
	`KSCE_ASSERT_NEXT(a_stall_hold, valid_s1 && !room,
		valid_s1 && $stable(evt_s1), "stalled event lost")
	// A two-byte event is always a break followed by the make of the same key.
	`KSCE_ASSERT_SAME(a_pair_form, fire && res.n_bytes == 2'd2,
		res.first_byte == (res.second_byte | 8'h80) && !res.second_byte[7],
		"bad break/make pair")
	// Bytes written to the queue must be offered on the next cycle.
	`KSCE_ASSERT_NEXT(a_push_shows, fire && res.n_bytes != 2'd0, m_tvalid,
		"queued byte not offered")

endmodule

`default_nettype wire

FILE: rtl/kbd_enc_keystate.sv
// Key state and byte generation: lock toggles, held-key map, scan ROM lookup.
// Depends on kbd_enc_pkg.
`default_nettype none

module kbd_enc_keystate (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kbd_enc_pkg::evt_t  evt,
	input  wire logic               fire,   // commit this event's state change
	output kbd_enc_pkg::res_t       res
);
	import kbd_enc_pkg::*;

	logic         caps_q;
	logic         kana_q;
	logic [127:0] pressed_q;

	logic       is_press;
	logic       is_caps;
	logic       is_kana;
	logic [7:0] ent;
	logic [6:0] sc;
	logic       held;
	logic       mapped;

	assign is_press = (evt.command == CmdPress);
	assign is_caps  = is_press && (evt.key_code == KeyCaps);
	assign is_kana  = is_press && (evt.key_code == KeyKana);
	assign ent      = scan_rom(evt.key_code);
	assign sc       = ent[6:0];
	assign mapped   = (ent != NoMap);
	assign held     = pressed_q[sc];

	always_comb begin
		res.n_bytes     = 2'd0;
		res.first_byte  = {1'b1, sc};
		res.second_byte = {1'b0, sc};
		if (is_caps) begin
			res.n_bytes    = evt.repeat_req ? 2'd0 : 2'd1;
			res.first_byte = {caps_q, ScanCaps};   // break bit when lock goes off
		end else if (is_kana) begin
			res.n_bytes    = evt.repeat_req ? 2'd0 : 2'd1;
			res.first_byte = {kana_q, ScanKana};
		end else if (mapped) begin
			if (is_press) begin
				res.n_bytes    = held ? 2'd2 : 2'd1;
				res.first_byte = {held, sc};
			end else begin
				res.n_bytes    = held ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_q    <= 1'b0;
			kana_q    <= 1'b0;
			pressed_q <= '0;
		end else if (fire) begin
			if (is_caps) begin
				if (!evt.repeat_req) caps_q <= !caps_q;
			end else if (is_kana) begin
				if (!evt.repeat_req) kana_q <= !kana_q;
			end else if (mapped) begin
				pressed_q[sc] <= is_press;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/kbd_enc_outq.sv
// Output byte queue: takes up to two bytes per event, sends one per transfer.
// Depends on kbd_enc_pkg.
`default_nettype none

module kbd_enc_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kbd_enc_pkg::res_t res,
	input  wire logic              push,     // res is written this cycle
	output logic                   room,     // space for two bytes
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,
	output logic                   m_tlast
);
	import kbd_enc_pkg::*;

	q_entry_t         mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	logic             pop;
	logic [1:0]       n_push;
	logic [QPtrW-1:0] wr_ptr_nx;

	assign room      = (cnt_q <= QCntW'(QDepth - 2));
	assign m_tvalid  = (cnt_q != '0);
	assign m_tdata   = mem_q[rd_ptr_q].scan_byte;
	assign m_tlast   = mem_q[rd_ptr_q].last;
	assign pop       = m_tvalid && m_tready;
	assign n_push    = push ? res.n_bytes : 2'd0;
	assign wr_ptr_nx = wr_ptr_q + QPtrW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			cnt_q <= cnt_q + QCntW'(n_push) - QCntW'(pop);
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= '{last: (n_push == 2'd1), scan_byte: res.first_byte};
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_nx] <= '{last: 1'b1, scan_byte: res.second_byte};
		end
	end

endmodule

`default_nettype wire
